@@ hw/rtl/srtci_pkg.sv @@
// Shared types and codes for the sorted record table.
// Holds the request and result beat structs; no dependencies.
package srtci_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        title_chunk;
        logic [31:0]        artist_chunk;
        logic               chunk_last;
        logic signed [31:0] year;
        logic [9:0]         position;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         hit_position;
        logic [9:0]         run_first;
        logic [10:0]        run_count;
        logic [10:0]        entry_total;
        logic [31:0]        out_title_chunk;
        logic [31:0]        out_artist_chunk;
        logic signed [31:0] out_year;
        logic               last;
    } rsp_t;

endpackage

@@ hw/rtl/sorted_record_table_case_insensitive.sv @@
// Sorted record table with case-folded title keys, top level.
// Depends on srtci_pkg for the request/result structs and codes.
//
//  channel  | handshake          | payload  | direction
//  ---------+--------------------+----------+----------
//  request  | start, busy        | req_t    | in
//  result   | done (1-cycle)     | rsp_t    | out
//
// A request beat is taken on start && !busy. Chunk beats without chunk_last
// are buffered as they are taken and keep busy low. The chunk_last beat runs the
// command on one shared word compare unit and one read and one write port
// per text memory: a compare reads and checks one title word at a time, a
// record move copies one word at a time, a lookup is a binary search plus a
// walk over the run of equal titles, and a read streams one row word by word.
// Reset (rst_n low, asynchronous) empties the table; stores need no clearing.
// Results are shown on done for one cycle each; the receiver cannot stall.
module sorted_record_table_case_insensitive #(
    parameter int CAPACITY   = 1024,
    parameter int TEXT_BYTES = 100
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  srtci_pkg::req_t request,
    output logic           done,
    output srtci_pkg::rsp_t result
);
    import srtci_pkg::*;

    localparam int WORDS = (TEXT_BYTES + 3) / 4;
    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int SW    = CW + 1;
    localparam int AW    = $clog2(CAPACITY * WORDS);
    localparam int WI    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WC    = $clog2(WORDS + 1);

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_C_RD      = 5'd1;
    localparam logic [4:0] S_C_CMP     = 5'd2;
    localparam logic [4:0] S_INS_SCAN  = 5'd3;
    localparam logic [4:0] S_INS_SCANR = 5'd4;
    localparam logic [4:0] S_SH_INIT   = 5'd5;
    localparam logic [4:0] S_SH_RD     = 5'd6;
    localparam logic [4:0] S_SH_WR     = 5'd7;
    localparam logic [4:0] S_YS_RD     = 5'd8;
    localparam logic [4:0] S_YS_WR     = 5'd9;
    localparam logic [4:0] S_SH_DONE   = 5'd10;
    localparam logic [4:0] S_INS_RD    = 5'd11;
    localparam logic [4:0] S_INS_WR    = 5'd12;
    localparam logic [4:0] S_RUN_DN    = 5'd13;
    localparam logic [4:0] S_RUN_DNR   = 5'd14;
    localparam logic [4:0] S_RUN_UP    = 5'd15;
    localparam logic [4:0] S_RUN_UPR   = 5'd16;
    localparam logic [4:0] S_RUN_END   = 5'd17;
    localparam logic [4:0] S_SRCH      = 5'd18;
    localparam logic [4:0] S_SRCHR     = 5'd19;
    localparam logic [4:0] S_RD_RD     = 5'd20;
    localparam logic [4:0] S_RD_OUT    = 5'd21;

    // Storage: flat text memories, one row of WORDS words per record.
    logic [31:0]        title_mem  [CAPACITY*WORDS];
    logic [31:0]        artist_mem [CAPACITY*WORDS];
    logic signed [31:0] year_mem   [CAPACITY];
    logic [31:0]        key_mem    [WORDS];
    logic [31:0]        art_mem    [WORDS];

    logic [4:0]         state_reg, state_next;
    logic [4:0]         ret_reg, ret_next;
    logic [CW-1:0]      total_reg, total_next;
    logic [WC-1:0]      cnt_reg, cnt_next;
    logic [WI-1:0]      w_reg, w_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [AW-1:0]      a_reg, a_next;
    logic [AW-1:0]      end_reg, end_next;
    logic [CW-1:0]      yi_reg, yi_next;
    logic [CW-1:0]      yend_reg, yend_next;
    logic [CW-1:0]      p_reg, p_next;
    logic [CW-1:0]      rf_reg, rf_next;
    logic [CW-1:0]      rl_reg, rl_next;
    logic signed [SW-1:0] lo_reg, lo_next;
    logic signed [SW-1:0] hi_reg, hi_next;
    logic [1:0]         cres_reg, cres_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic signed [31:0] year_reg, year_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               done_reg, done_next;
    rsp_t               result_reg, result_next;

    logic               buf_we;
    logic               tw_en;
    logic [AW-1:0]      tw_addr;
    logic [31:0]        tw_title, tw_artist;
    logic [AW-1:0]      tr_addr;
    logic               yw_en;
    logic [IW-1:0]      yw_addr, yr_addr;
    logic signed [31:0] yw_data;
    logic [31:0]        t_q, a_q, kq, aq;
    logic signed [31:0] y_q;

    function automatic logic [7:0] fold(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
            r = b + 8'h20;
        return r;
    endfunction

    // Lowest differing byte decides the order.
    function automatic logic [1:0] cmp_word(input logic [31:0] k, input logic [31:0] t);
        logic [7:0] x, y;
        logic [1:0] r;
        r = CMP_EQ;
        for (int i = 3; i >= 0; i--)
        begin
            x = fold(k[8*i +: 8]);
            y = fold(t[8*i +: 8]);
            if (x != y)
                r = (x < y) ? CMP_LT : CMP_GT;
        end
        return r;
    endfunction

    function automatic logic [AW:0] mulw(input logic [CW-1:0] x);
        logic [AW:0] xe;
        xe = (AW+1)'(x);
        return xe * (AW+1)'(WORDS);
    endfunction

    function automatic logic [9:0] fit10(input logic [CW-1:0] x);
        logic [CW+10:0] t;
        t = (CW+11)'(x);
        return t[9:0];
    endfunction

    function automatic logic [10:0] fit11(input logic [CW-1:0] x);
        logic [CW+10:0] t;
        t = (CW+11)'(x);
        return t[10:0];
    endfunction

    // Memories: one write and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            title_mem[tw_addr]  <= tw_title;
            artist_mem[tw_addr] <= tw_artist;
        end
        t_q <= title_mem[tr_addr];
        a_q <= artist_mem[tr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (yw_en)
            year_mem[yw_addr] <= yw_data;
        y_q <= year_mem[yr_addr];
    end

    // Chunk buffers; entries at or above the fill count read as zero.
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            key_mem[cnt_reg[WI-1:0]] <= request.title_chunk;
            art_mem[cnt_reg[WI-1:0]] <= request.artist_chunk;
        end
        kq <= key_mem[w_reg];
        aq <= art_mem[w_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        w_reg      <= w_next;
        base_reg   <= base_next;
        a_reg      <= a_next;
        end_reg    <= end_next;
        yi_reg     <= yi_next;
        yend_reg   <= yend_next;
        p_reg      <= p_next;
        rf_reg     <= rf_next;
        rl_reg     <= rl_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        cres_reg   <= cres_next;
        cmd_reg    <= cmd_next;
        year_reg   <= year_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    logic               kvalid;
    logic [1:0]         cmp_now;
    logic signed [SW-1:0] mid;
    logic [AW:0]        dst;
    logic [CW-1:0]      ydst;
    logic [CW-1:0]      rcount;

    assign kvalid  = (WC+WI)'(w_reg) < (WC+WI)'(cnt_reg);
    assign cmp_now = cmp_word(kvalid ? kq : 32'd0, t_q);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign rcount  = rl_reg - rf_reg + CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        total_next  = total_reg;
        cnt_next    = cnt_reg;
        w_next      = w_reg;
        base_next   = base_reg;
        a_next      = a_reg;
        end_next    = end_reg;
        yi_next     = yi_reg;
        yend_next   = yend_reg;
        p_next      = p_reg;
        rf_next     = rf_reg;
        rl_next     = rl_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cres_next   = cres_reg;
        cmd_next    = cmd_reg;
        year_next   = year_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        result_next = '0;
        buf_we      = 1'b0;
        tw_en       = 1'b0;
        tw_addr     = a_reg;
        tw_title    = t_q;
        tw_artist   = a_q;
        tr_addr     = base_reg + AW'(w_reg);
        yw_en       = 1'b0;
        yw_addr     = yi_reg[IW-1:0];
        yw_data     = y_q;
        yr_addr     = yi_reg[IW-1:0];
        dst         = '0;
        ydst        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cnt_reg < WC'(WORDS))
                    begin
                        buf_we   = 1'b1;
                        cnt_next = cnt_reg + WC'(1);
                    end
                    if (request.chunk_last)
                    begin
                        cmd_next  = request.command;
                        year_next = request.year;
                        pos_next  = CW'(request.position);
                        case (request.command)
                            CMD_INSERT:
                            begin
                                if (total_reg >= CW'(CAPACITY))
                                begin
                                    done_next          = 1'b1;
                                    result_next.status = ST_FULL;
                                    result_next.last   = 1'b1;
                                    cnt_next           = '0;
                                end
                                else
                                begin
                                    p_next     = '0;
                                    state_next = S_INS_SCAN;
                                end
                            end
                            CMD_DELETE, CMD_LOOKUP:
                            begin
                                lo_next    = '0;
                                hi_next    = $signed({1'b0, total_reg}) - SW'(1);
                                state_next = S_SRCH;
                            end
                            default:
                            begin
                                if (32'(request.position) >= 32'(total_reg))
                                begin
                                    done_next          = 1'b1;
                                    result_next.status = ST_BAD_POS;
                                    result_next.last   = 1'b1;
                                    cnt_next           = '0;
                                end
                                else
                                begin
                                    base_next  = AW'(mulw(CW'(request.position)));
                                    w_next     = '0;
                                    state_next = S_RD_RD;
                                end
                            end
                        endcase
                    end
                end
            end

            // Shared compare unit: key versus the title row at base_reg.
            S_C_RD:
            begin
                state_next = S_C_CMP;
            end
            S_C_CMP:
            begin
                if (cmp_now != CMP_EQ || w_reg == WI'(WORDS - 1))
                begin
                    cres_next  = cmp_now;
                    state_next = ret_reg;
                end
                else
                begin
                    w_next     = w_reg + WI'(1);
                    state_next = S_C_RD;
                end
            end

            // Insert: walk past every title not above the key.
            S_INS_SCAN:
            begin
                if (p_reg < total_reg)
                begin
                    base_next  = AW'(mulw(p_reg));
                    w_next     = '0;
                    ret_next   = S_INS_SCANR;
                    state_next = S_C_RD;
                end
                else
                    state_next = S_SH_INIT;
            end
            S_INS_SCANR:
            begin
                if (cres_reg != CMP_LT)
                begin
                    p_next     = p_reg + CW'(1);
                    state_next = S_INS_SCAN;
                end
                else
                    state_next = S_SH_INIT;
            end

            // Set up the row move: down for insert, up for delete.
            S_SH_INIT:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    a_next    = AW'(mulw(total_reg) - (AW+1)'(1));
                    end_next  = AW'(mulw(p_reg));
                    yi_next   = total_reg - CW'(1);
                    yend_next = p_reg;
                    state_next = (p_reg < total_reg) ? S_SH_RD : S_SH_DONE;
                end
                else
                begin
                    a_next    = AW'(mulw(p_reg + CW'(1)));
                    end_next  = AW'(mulw(total_reg) - (AW+1)'(1));
                    yi_next   = p_reg + CW'(1);
                    yend_next = total_reg - CW'(1);
                    state_next = ((p_reg + CW'(1)) < total_reg) ? S_SH_RD : S_SH_DONE;
                end
            end
            S_SH_RD:
            begin
                tr_addr    = a_reg;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                if (cmd_reg == CMD_INSERT)
                    dst = (AW+1)'(a_reg) + (AW+1)'(WORDS);
                else
                    dst = (AW+1)'(a_reg) - (AW+1)'(WORDS);
                tw_en   = 1'b1;
                tw_addr = dst[AW-1:0];
                if (a_reg == end_reg)
                    state_next = S_YS_RD;
                else
                begin
                    a_next     = (cmd_reg == CMD_INSERT) ? a_reg - AW'(1) : a_reg + AW'(1);
                    state_next = S_SH_RD;
                end
            end
            S_YS_RD:
            begin
                state_next = S_YS_WR;
            end
            S_YS_WR:
            begin
                ydst    = (cmd_reg == CMD_INSERT) ? yi_reg + CW'(1) : yi_reg - CW'(1);
                yw_en   = 1'b1;
                yw_addr = ydst[IW-1:0];
                if (yi_reg == yend_reg)
                    state_next = S_SH_DONE;
                else
                begin
                    yi_next    = (cmd_reg == CMD_INSERT) ? yi_reg - CW'(1) : yi_reg + CW'(1);
                    state_next = S_YS_RD;
                end
            end
            S_SH_DONE:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    base_next  = AW'(mulw(p_reg));
                    w_next     = '0;
                    state_next = S_INS_RD;
                end
                else
                begin
                    total_next               = total_reg - CW'(1);
                    done_next                = 1'b1;
                    result_next.status       = ST_OK;
                    result_next.hit_position = fit10(p_reg);
                    result_next.run_first    = fit10(rf_reg);
                    result_next.run_count    = fit11(rcount);
                    result_next.last         = 1'b1;
                    cnt_next                 = '0;
                    state_next               = S_IDLE;
                end
            end

            // Write the buffered record into the opened row.
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                tw_en     = 1'b1;
                tw_addr   = base_reg + AW'(w_reg);
                tw_title  = kvalid ? kq : 32'd0;
                tw_artist = kvalid ? aq : 32'd0;
                if (w_reg == WI'(WORDS - 1))
                begin
                    yw_en      = 1'b1;
                    yw_addr    = p_reg[IW-1:0];
                    yw_data    = year_reg;
                    total_next = total_reg + CW'(1);
                    rf_next    = p_reg;
                    rl_next    = p_reg;
                    state_next = S_RUN_DN;
                end
                else
                begin
                    w_next     = w_reg + WI'(1);
                    state_next = S_INS_RD;
                end
            end

            // Grow the run of equal titles in both directions.
            S_RUN_DN:
            begin
                if (rf_reg != '0)
                begin
                    base_next  = AW'(mulw(rf_reg - CW'(1)));
                    w_next     = '0;
                    ret_next   = S_RUN_DNR;
                    state_next = S_C_RD;
                end
                else
                    state_next = S_RUN_UP;
            end
            S_RUN_DNR:
            begin
                if (cres_reg == CMP_EQ)
                begin
                    rf_next    = rf_reg - CW'(1);
                    state_next = S_RUN_DN;
                end
                else
                    state_next = S_RUN_UP;
            end
            S_RUN_UP:
            begin
                if ((CW+1)'(rl_reg) + (CW+1)'(1) < (CW+1)'(total_reg))
                begin
                    base_next  = AW'(mulw(rl_reg + CW'(1)));
                    w_next     = '0;
                    ret_next   = S_RUN_UPR;
                    state_next = S_C_RD;
                end
                else
                    state_next = S_RUN_END;
            end
            S_RUN_UPR:
            begin
                if (cres_reg == CMP_EQ)
                begin
                    rl_next    = rl_reg + CW'(1);
                    state_next = S_RUN_UP;
                end
                else
                    state_next = S_RUN_END;
            end
            S_RUN_END:
            begin
                if (cmd_reg == CMD_DELETE)
                    state_next = S_SH_INIT;
                else
                begin
                    done_next                = 1'b1;
                    result_next.status       = ST_OK;
                    result_next.hit_position = fit10(p_reg);
                    result_next.run_first    = fit10(rf_reg);
                    result_next.run_count    = fit11(rcount);
                    result_next.last         = 1'b1;
                    cnt_next                 = '0;
                    state_next               = S_IDLE;
                end
            end

            // Binary search over the sorted rows.
            S_SRCH:
            begin
                if (lo_reg <= hi_reg)
                begin
                    p_next     = mid[CW-1:0];
                    base_next  = AW'(mulw(mid[CW-1:0]));
                    w_next     = '0;
                    ret_next   = S_SRCHR;
                    state_next = S_C_RD;
                end
                else
                begin
                    done_next          = 1'b1;
                    result_next.status = ST_NOT_FOUND;
                    result_next.last   = 1'b1;
                    cnt_next           = '0;
                    state_next         = S_IDLE;
                end
            end
            S_SRCHR:
            begin
                if (cres_reg == CMP_EQ)
                begin
                    rf_next    = p_reg;
                    rl_next    = p_reg;
                    state_next = S_RUN_DN;
                end
                else
                begin
                    if (cres_reg == CMP_LT)
                        hi_next = $signed({1'b0, p_reg}) - SW'(1);
                    else
                        lo_next = $signed({1'b0, p_reg}) + SW'(1);
                    state_next = S_SRCH;
                end
            end

            // Stream one row, one word per result beat.
            S_RD_RD:
            begin
                yr_addr    = pos_reg[IW-1:0];
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                done_next                    = 1'b1;
                result_next.status           = ST_OK;
                result_next.hit_position     = fit10(pos_reg);
                result_next.out_title_chunk  = t_q;
                result_next.out_artist_chunk = a_q;
                result_next.out_year         = y_q;
                if (w_reg == WI'(WORDS - 1))
                begin
                    result_next.last = 1'b1;
                    cnt_next         = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    w_next     = w_reg + WI'(1);
                    state_next = S_RD_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.entry_total = fit11(total_next);
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ bench/sorted_record_table_case_insensitive_tb.sv @@
// Self-checking bench for the case-folded sorted record table.
// Needs srtci_pkg and sorted_record_table_case_insensitive; reads nothing else.
`timescale 1ns / 1ps

module sorted_record_table_case_insensitive_tb;
    import srtci_pkg::*;

    localparam int CAP        = 1024;
    localparam int WORDS      = 25;
    localparam int TABLE_SOFT = 36;          // keep the table small so shifts stay cheap
    localparam int BEAT_GOAL  = 230;
    localparam longint CYCLE_LIMIT = 4000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t result;

    sorted_record_table_case_insensitive DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow of the table: titles, artists and years in sorted order,
    // plus the chunk buffers that fill until the closing beat.
    // ------------------------------------------------------------------
    logic [31:0] shadow_title  [CAP][WORDS];
    logic [31:0] shadow_artist [CAP][WORDS];
    logic [31:0] shadow_year   [CAP];
    int          shadow_total;
    logic [31:0] key_words    [WORDS];
    logic [31:0] artist_words [WORDS];
    int          words_held;

    rsp_t expected_results[$];
    int   fail_count;
    int   results_checked;
    int   beats_sent;
    int   cmd_seen[4];
    bit   quiet;                              // no sender gaps while set
    longint cycle_count;

    function automatic logic [7:0] fold_byte(logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A)
            return b + 8'h20;
        return b;
    endfunction

    // Sign of (buffered key - stored title at idx), all bytes, letters folded.
    function automatic int title_order(int idx);
        logic [7:0] a;
        logic [7:0] b;
        for (int w = 0; w < WORDS; w++)
        begin
            for (int s = 0; s < 32; s += 8)
            begin
                a = fold_byte(key_words[w][s +: 8]);
                b = fold_byte(shadow_title[idx][w][s +: 8]);
                if (a != b)
                    return (a < b) ? -1 : 1;
            end
        end
        return 0;
    endfunction

    function automatic int search_title();
        int lo;
        int hi;
        int mid;
        int c;
        lo = 0;
        hi = shadow_total - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            c = title_order(mid);
            if (c == 0)
                return mid;
            if (c < 0)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    task automatic equal_run(input int hit, output int first, output int count);
        int a;
        int b;
        a = hit;
        b = hit;
        while (a > 0 && title_order(a - 1) == 0)
            a--;
        while (b + 1 < shadow_total && title_order(b + 1) == 0)
            b++;
        first = a;
        count = b - a + 1;
    endtask

    function automatic rsp_t status_beat(logic [1:0] st, int hit, int first, int count);
        rsp_t r;
        r = '0;
        r.status       = st;
        r.hit_position = hit[9:0];
        r.run_first    = first[9:0];
        r.run_count    = count[10:0];
        r.entry_total  = shadow_total[10:0];
        r.last         = 1'b1;
        return r;
    endfunction

    // Advance the shadow by one accepted beat and return what it must produce.
    task automatic table_step(input req_t rq, output rsp_t outs[$]);
        int p;
        int first;
        int count;
        rsp_t r;
        outs = {};
        if (words_held < WORDS)
        begin
            key_words[words_held]    = rq.title_chunk;
            artist_words[words_held] = rq.artist_chunk;
            words_held++;
        end
        if (!rq.chunk_last)
            return;
        cmd_seen[rq.command]++;
        case (rq.command)
            CMD_INSERT:
            begin
                if (shadow_total >= CAP)
                    outs.push_back(status_beat(ST_FULL, 0, 0, 0));
                else
                begin
                    p = 0;
                    while (p < shadow_total && title_order(p) >= 0)
                        p++;
                    for (int i = shadow_total; i > p; i--)
                    begin
                        shadow_title[i]  = shadow_title[i - 1];
                        shadow_artist[i] = shadow_artist[i - 1];
                        shadow_year[i]   = shadow_year[i - 1];
                    end
                    shadow_title[p]  = key_words;
                    shadow_artist[p] = artist_words;
                    shadow_year[p]   = rq.year;
                    shadow_total++;
                    equal_run(p, first, count);
                    outs.push_back(status_beat(ST_OK, p, first, count));
                end
            end
            CMD_DELETE, CMD_LOOKUP:
            begin
                p = search_title();
                if (p < 0)
                    outs.push_back(status_beat(ST_NOT_FOUND, 0, 0, 0));
                else
                begin
                    equal_run(p, first, count);
                    if (rq.command == CMD_DELETE)
                    begin
                        for (int i = p; i < shadow_total - 1; i++)
                        begin
                            shadow_title[i]  = shadow_title[i + 1];
                            shadow_artist[i] = shadow_artist[i + 1];
                            shadow_year[i]   = shadow_year[i + 1];
                        end
                        shadow_total--;
                    end
                    outs.push_back(status_beat(ST_OK, p, first, count));
                end
            end
            default:
            begin
                if (rq.position >= shadow_total)
                    outs.push_back(status_beat(ST_BAD_POS, 0, 0, 0));
                else
                begin
                    for (int k = 0; k < WORDS; k++)
                    begin
                        r = status_beat(ST_OK, rq.position, 0, 0);
                        r.out_title_chunk  = shadow_title[rq.position][k];
                        r.out_artist_chunk = shadow_artist[rq.position][k];
                        r.out_year         = shadow_year[rq.position];
                        r.last             = (k == WORDS - 1);
                        outs.push_back(r);
                    end
                end
            end
        endcase
        for (int w = 0; w < WORDS; w++)
        begin
            key_words[w]    = '0;
            artist_words[w] = '0;
        end
        words_held = 0;
    endtask

    // ------------------------------------------------------------------
    // Request side. Hold start across back-to-back beats; drop it before a
    // beat about 16 times in a hundred unless a quiet stretch runs.
    // The beat is taken at the edge where busy was low.
    // ------------------------------------------------------------------
    task automatic send_beat(input req_t rq, input bit use_typed, input rsp_t typed);
        rsp_t outs[$];
        if (!quiet && $urandom_range(99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
        table_step(rq, outs);
        if (use_typed && outs.size() != 0)
            expected_results.push_back(typed);
        else
            foreach (outs[i])
                expected_results.push_back(outs[i]);
    endtask

    function automatic logic [31:0] text_chunk(string s, int k);
        logic [31:0] c;
        c = '0;
        for (int b = 0; b < 4; b++)
            if (4 * k + b < s.len())
                c[8 * b +: 8] = s[4 * k + b];
        return c;
    endfunction

    // Send one whole command: the text split over chunks, command on the last.
    task automatic send_command(input logic [1:0] cmd, input string title,
                                input int chunks, input logic [31:0] yr,
                                input logic [9:0] pos, input bit noise_text);
        req_t rq;
        for (int k = 0; k < chunks; k++)
        begin
            rq.command      = (k == chunks - 1) ? cmd : 2'($urandom_range(3));
            rq.title_chunk  = noise_text ? $urandom : text_chunk(title, k);
            rq.artist_chunk = $urandom;
            rq.chunk_last   = (k == chunks - 1);
            rq.year         = yr;
            rq.position     = pos;
            send_beat(rq, 1'b0, '0);
        end
    endtask

    // Random letter case so that equal titles arrive in different spellings.
    function automatic string shuffle_case(string s);
        string t;
        t = s;
        for (int i = 0; i < t.len(); i++)
            if ($urandom_range(1) && ((t[i] >= "a" && t[i] <= "z") ||
                                      (t[i] >= "A" && t[i] <= "Z")))
                t[i] = t[i] ^ 8'h20;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Result side: every done cycle must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: %p", result);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                results_checked++;
                if (result.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, result.status);
                    fail_count++;
                end
                if (result.hit_position !== e.hit_position)
                begin
                    $error("hit_position: expected %0d, got %0d", e.hit_position,
                           result.hit_position);
                    fail_count++;
                end
                if (result.run_first !== e.run_first)
                begin
                    $error("run_first: expected %0d, got %0d", e.run_first, result.run_first);
                    fail_count++;
                end
                if (result.run_count !== e.run_count)
                begin
                    $error("run_count: expected %0d, got %0d", e.run_count, result.run_count);
                    fail_count++;
                end
                if (result.entry_total !== e.entry_total)
                begin
                    $error("entry_total: expected %0d, got %0d", e.entry_total,
                           result.entry_total);
                    fail_count++;
                end
                if (result.out_title_chunk !== e.out_title_chunk)
                begin
                    $error("out_title_chunk: expected %h, got %h", e.out_title_chunk,
                           result.out_title_chunk);
                    fail_count++;
                end
                if (result.out_artist_chunk !== e.out_artist_chunk)
                begin
                    $error("out_artist_chunk: expected %h, got %h", e.out_artist_chunk,
                           result.out_artist_chunk);
                    fail_count++;
                end
                if (result.out_year !== e.out_year)
                begin
                    $error("out_year: expected %0d, got %0d", e.out_year, result.out_year);
                    fail_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last: expected %0b, got %0b", e.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table: expected beat typed in only where it is obvious
    // (empty table, error codes); other rows go through the shadow.
    // ------------------------------------------------------------------
    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t exp;
    } stim_row_t;

    function automatic req_t mk(logic [1:0] cmd, logic [31:0] t, logic [31:0] a,
                                logic lst, logic [31:0] yr, logic [9:0] pos);
        req_t r;
        r.command      = cmd;
        r.title_chunk  = t;
        r.artist_chunk = a;
        r.chunk_last   = lst;
        r.year         = yr;
        r.position     = pos;
        return r;
    endfunction

    function automatic rsp_t fixed_fail(logic [1:0] st, int total);
        rsp_t r;
        r = '0;
        r.status      = st;
        r.entry_total = total[10:0];
        r.last        = 1'b1;
        return r;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        string pool[8];
        string pick;
        int choice;
        int chunks;

        pool = '{"alpha", "Beta", "gamma ray burst", "delta", "x",
                 "zulu quartet band of many", "", "mixedCase"};
        fail_count = 0;
        results_checked = 0;
        beats_sent = 0;
        cmd_seen = '{0, 0, 0, 0};
        cycle_count = 0;
        quiet = 1'b0;
        shadow_total = 0;
        words_held = 0;
        for (int w = 0; w < WORDS; w++)
        begin
            key_words[w]    = '0;
            artist_words[w] = '0;
        end
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: every search misses, every read is out of range.
        rows.push_back('{mk(CMD_LOOKUP, 32'("cba"), 0, 1, 0, 0), 1,
                         fixed_fail(ST_NOT_FOUND, 0)});
        rows.push_back('{mk(CMD_READ, 0, 0, 1, 0, 10'd0), 1, fixed_fail(ST_BAD_POS, 0)});
        rows.push_back('{mk(CMD_DELETE, 0, 0, 1, 0, 0), 1, fixed_fail(ST_NOT_FOUND, 0)});
        // Two-chunk title "Hello", then the same title in capitals: one run.
        rows.push_back('{mk(CMD_READ, text_chunk("Hello", 0), 32'h0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_INSERT, text_chunk("Hello", 1), 32'hFFFF_FFFF, 1,
                            32'h8000_0000, 0), 0, '0});
        rows.push_back('{mk(CMD_INSERT, text_chunk("HELL", 0), 32'h0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_INSERT, text_chunk("O", 0), 32'h1234_5678, 1,
                            32'h7FFF_FFFF, 0), 0, '0});
        // All-ones bytes sort last; the empty title sorts first.
        rows.push_back('{mk(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF,
                            10'h3FF), 0, '0});
        rows.push_back('{mk(CMD_INSERT, 32'h0, 32'h0, 1, 32'h0, 0), 0, '0});
        rows.push_back('{mk(CMD_LOOKUP, text_chunk("hELL", 0), 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_LOOKUP, text_chunk("hello", 1), 0, 1, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_READ, 0, 0, 1, 0, 10'd1), 0, '0});
        rows.push_back('{mk(CMD_READ, 0, 0, 1, 0, 10'd3), 0, '0});
        rows.push_back('{mk(CMD_READ, 0, 0, 1, 0, 10'h3FF), 1, fixed_fail(ST_BAD_POS, 4)});
        rows.push_back('{mk(CMD_LOOKUP, "nope", 0, 1, 0, 0), 1, fixed_fail(ST_NOT_FOUND, 4)});
        rows.push_back('{mk(CMD_DELETE, text_chunk("hello", 0), 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_DELETE, text_chunk("hello", 1), 0, 1, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_DELETE, 32'hFFFF_FFFF, 0, 1, 0, 0), 0, '0});
        rows.push_back('{mk(CMD_READ, 0, 0, 1, 0, 10'd1), 0, '0});
        foreach (rows[i])
            send_beat(rows[i].rq, rows[i].typed, rows[i].exp);

        // Too many chunks: 27 beats, the last two dropped by the block.
        send_command(CMD_INSERT, "", 27, 32'd1999, 0, 1'b1);

        // Random part: mostly well-formed commands on a pool of titles in
        // mixed case, some random-bit titles, long overflowing texts and reads.
        while (beats_sent < BEAT_GOAL)
        begin
            quiet = (beats_sent > 110 && beats_sent < 160);
            pick = shuffle_case(pool[$urandom_range(7)]);
            chunks = (pick.len() + 3) / 4;
            if (chunks == 0)
                chunks = 1;
            if ($urandom_range(19) == 0)
                chunks = $urandom_range(WORDS - 1, WORDS + 2);
            choice = $urandom_range(99);
            if (shadow_total >= TABLE_SOFT && choice < 45)
                choice = 50;
            if (choice < 35)
                send_command(CMD_INSERT, pick, chunks, $urandom, 10'($urandom), 1'b0);
            else if (choice < 45)
                send_command(CMD_INSERT, pick, $urandom_range(1, 3), $urandom,
                             10'($urandom), 1'b1);
            else if (choice < 65)
                send_command(CMD_DELETE, pick, chunks, $urandom, 10'($urandom), 1'b0);
            else if (choice < 80)
                send_command(CMD_LOOKUP, pick, chunks, $urandom, 10'($urandom), 1'b0);
            else if (choice < 93 && shadow_total > 0)
                send_command(CMD_READ, pick, 1, $urandom,
                             10'($urandom_range(shadow_total - 1)), 1'b0);
            else
                send_command(CMD_READ, pick, 1, $urandom, 10'($urandom), 1'b1);
        end
        start <= 1'b0;

        // Drain: wait for every expected beat, then a short settle window.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4 * WORDS) @(posedge clk);

        $display("%0d request beats: %0d inserts, %0d deletes, %0d lookups, %0d reads",
                 beats_sent, cmd_seen[CMD_INSERT], cmd_seen[CMD_DELETE],
                 cmd_seen[CMD_LOOKUP], cmd_seen[CMD_READ]);
        $display("%0d result beats checked, %0d records left in the table",
                 results_checked, shadow_total);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/srtci_pkg.sv
hw/rtl/sorted_record_table_case_insensitive.sv
bench/sorted_record_table_case_insensitive_tb.sv
